>>> rtl/wgg_pkg.sv
package wgg_pkg;

  localparam int ROBOTS      = 10;
  localparam int QUEUE_DEPTH = 16;
  localparam int RIDX_W      = (ROBOTS > 1) ? $clog2(ROBOTS) : 1;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_LIN_GAIN = 2'd0;
  localparam logic [1:0] CFG_ANG_GAIN = 2'd1;
  localparam logic [1:0] CFG_THRESH   = 2'd2;

  localparam logic [15:0] LIN_GAIN_RST = 16'd6144;
  localparam logic [15:0] ANG_GAIN_RST = 16'd18432;
  localparam logic [15:0] THRESH_RST   = 16'd41;

  // angles in signed q.16 radians
  localparam logic signed [21:0] ANG_PI      = 22'sd205887;
  localparam logic signed [21:0] ANG_HALF_PI = 22'sd102944;
  localparam logic signed [21:0] ANG_TWO_PI  = 22'sd411775;

  localparam logic [4:0] SQRT_STEPS_M1 = 5'd16;

  typedef enum logic [4:0] {
    S_IDLE, S_GOAL, S_DIFF, S_SQX, S_SQY, S_SUM, S_CHK, S_SQRT, S_LIN, S_LINC,
    S_CORDIC, S_ERR, S_WRAP, S_FOLD, S_ANG, S_ANGC, S_OUT
  } wgg_state_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [31:0] wdata;
  } wgg_qctl_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic [31:0]       head;
  } wgg_qstat_t;

  function automatic logic [16:0] atan_step(input logic [3:0] i);
    logic [16:0] v;
    unique case (i)
      4'd0:    v = 17'd51472;
      4'd1:    v = 17'd30386;
      4'd2:    v = 17'd16055;
      4'd3:    v = 17'd8150;
      4'd4:    v = 17'd4091;
      4'd5:    v = 17'd2047;
      4'd6:    v = 17'd1024;
      4'd7:    v = 17'd512;
      4'd8:    v = 17'd256;
      4'd9:    v = 17'd128;
      4'd10:   v = 17'd64;
      4'd11:   v = 17'd32;
      4'd12:   v = 17'd16;
      4'd13:   v = 17'd8;
      4'd14:   v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/wgg_mul.sv
module wgg_mul (
  input  logic               clk,
  input  logic signed [17:0] a,
  input  logic signed [22:0] b,
  output logic signed [40:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= 41'(a) * 41'(b);
  end

endmodule

>>> rtl/wgg_queue.sv
module wgg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  wgg_pkg::wgg_qctl_t  ctl,
  output wgg_pkg::wgg_qstat_t stat
);

  logic [31:0]                  mem [wgg_pkg::QUEUE_DEPTH];
  logic [wgg_pkg::QPTR_W-1:0]   rd_ptr_r, wr_ptr_r;
  logic [wgg_pkg::QCNT_W-1:0]   count_r;
  logic [31:0]                  head_r;

  localparam logic [wgg_pkg::QPTR_W-1:0] PTR_LAST =
    wgg_pkg::QPTR_W'(wgg_pkg::QUEUE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.wdata;
    end
    head_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (ctl.pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
        count_r <= count_r + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign stat.count = count_r;
  assign stat.head  = head_r;

endmodule

>>> rtl/waypoint_go_to_goal_steering.sv
// go-to-goal steering for a set of robots sharing one waypoint queue
//
// in channel: in_tuser is the item kind (0 pose sample, 1 waypoint push),
// in_tdata carries robot, pos_x, pos_y and heading. every accepted item
// gives exactly one out item: linear_speed, angular_rate and the arrived,
// took_waypoint and dropped flags.
// waypoint pushes and out-of-range robots go from idle straight to the output.
// a pose item runs a small sequencer around one shared 18x23 multiplier, a
// bit-per-cycle square root (17 steps), a 16 step cordic vectoring and a
// wrap step when the heading error needs one; a robot on its goal, or in
// reach with no waypoint to take, skips root and cordic, and a taken one
// repeats the distance steps; in_tready low meanwhile, high with out_tvalid.
// in_tready is high whenever the sequencer is idle, even while a result
// waits in the output register; a new result waits at the end of its run
// until the held one is taken, so a stalled receiver holds the whole block.
// the cfg port writes gains and threshold; write only when idle.
// reset (synchronous, active low) empties the queue, forgets every goal and
// restores the default gains and threshold.
module waypoint_go_to_goal_steering (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // robot, pos_x, pos_y, heading, zero pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // linear_speed, angular_rate, arrived,
                                  // took_waypoint, dropped, zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int RW = wgg_pkg::RIDX_W;

  wgg_pkg::wgg_state_t state_r, state_nxt;

  logic [15:0] lin_gain_r, ang_gain_r, thresh_r;

  logic [RW-1:0]       robot_r, robot_nxt;
  logic [15:0]         px_r, px_nxt, py_r, py_nxt;
  logic signed [14:0]  hd_r, hd_nxt;
  logic signed [16:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [31:0]         thr2_r, thr2_nxt;
  logic [32:0]         sx_r, sx_nxt, s_r, s_nxt;
  logic [33:0]         v_r, v_nxt, rt_r, rt_nxt, b_r, b_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic signed [31:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [19:0]  z_r, z_nxt;
  logic signed [21:0]  err_r, err_nxt;
  logic [15:0]         res_lin_r, res_lin_nxt;
  logic signed [15:0]  res_ang_r, res_ang_nxt;
  logic                res_arr_r, res_arr_nxt, res_took_r, res_took_nxt;
  logic                res_drop_r, res_drop_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [39:0]         out_data_r, out_data_nxt;

  logic [15:0] goal_x [wgg_pkg::ROBOTS];
  logic [15:0] goal_y [wgg_pkg::ROBOTS];
  logic [wgg_pkg::ROBOTS-1:0] goal_set_r;
  logic        goal_we, goal_init;
  logic [15:0] goal_wx, goal_wy;

  logic signed [17:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [40:0] mul_p;

  wgg_pkg::wgg_qctl_t  qctl;
  wgg_pkg::wgg_qstat_t qstat;

  logic               accept;
  logic               q_full;
  logic [34:0]        rb_sum;
  logic signed [31:0] xs, ys;
  logic signed [19:0] atan_v;
  logic signed [24:0] ang_q;
  logic signed [16:0] cdx, cdy;

  wgg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));
  wgg_queue u_queue (.clk(clk), .rst_n(rst_n), .ctl(qctl), .stat(qstat));

  assign in_tready  = (state_r == wgg_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign q_full     = (qstat.count >= wgg_pkg::QCNT_W'(wgg_pkg::QUEUE_DEPTH));

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_gain_r <= wgg_pkg::LIN_GAIN_RST;
      ang_gain_r <= wgg_pkg::ANG_GAIN_RST;
      thresh_r   <= wgg_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wgg_pkg::CFG_LIN_GAIN: lin_gain_r <= cfg_wdata;
        wgg_pkg::CFG_ANG_GAIN: ang_gain_r <= cfg_wdata;
        wgg_pkg::CFG_THRESH:   thresh_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // goal store, no reset on the coordinates
  always_ff @(posedge clk) begin
    if (goal_we) begin
      goal_x[robot_r] <= goal_wx;
      goal_y[robot_r] <= goal_wy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_set_r <= '0;
    end else if (goal_init) begin
      goal_set_r[robot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wgg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    robot_r    <= robot_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    hd_r       <= hd_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    thr2_r     <= thr2_nxt;
    sx_r       <= sx_nxt;
    s_r        <= s_nxt;
    v_r        <= v_nxt;
    rt_r       <= rt_nxt;
    b_r        <= b_nxt;
    cnt_r      <= cnt_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    err_r      <= err_nxt;
    res_lin_r  <= res_lin_nxt;
    res_ang_r  <= res_ang_nxt;
    res_arr_r  <= res_arr_nxt;
    res_took_r <= res_took_nxt;
    res_drop_r <= res_drop_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    robot_nxt     = robot_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    hd_nxt        = hd_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    thr2_nxt      = thr2_r;
    sx_nxt        = sx_r;
    s_nxt         = s_r;
    v_nxt         = v_r;
    rt_nxt        = rt_r;
    b_nxt         = b_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    err_nxt       = err_r;
    res_lin_nxt   = res_lin_r;
    res_ang_nxt   = res_ang_r;
    res_arr_nxt   = res_arr_r;
    res_took_nxt  = res_took_r;
    res_drop_nxt  = res_drop_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    goal_we       = 1'b0;
    goal_init     = 1'b0;
    goal_wx       = px_r;
    goal_wy       = py_r;
    qctl.push     = 1'b0;
    qctl.pop      = 1'b0;
    qctl.wdata    = {in_tdata[19:4], in_tdata[35:20]};
    mul_a         = '0;
    mul_b         = '0;
    rb_sum        = 35'(rt_r) + 35'(b_r);
    xs            = x_r >>> cnt_r[3:0];
    ys            = y_r >>> cnt_r[3:0];
    atan_v        = 20'(wgg_pkg::atan_step(cnt_r[3:0]));
    ang_q         = mul_p[40:16];
    cdx           = dx_r;
    cdy           = dy_r;

    unique case (state_r)
      wgg_pkg::S_IDLE: begin
        if (accept) begin
          robot_nxt    = RW'(in_tdata[3:0]);
          px_nxt       = in_tdata[19:4];
          py_nxt       = in_tdata[35:20];
          hd_nxt       = $signed(in_tdata[50:36]);
          res_lin_nxt  = '0;
          res_ang_nxt  = '0;
          res_arr_nxt  = 1'b0;
          res_took_nxt = 1'b0;
          res_drop_nxt = 1'b0;
          if (in_tuser) begin
            res_drop_nxt = q_full;
            qctl.push    = !q_full;
            state_nxt    = wgg_pkg::S_OUT;
          end else if (int'(in_tdata[3:0]) >= wgg_pkg::ROBOTS) begin
            state_nxt = wgg_pkg::S_OUT;
          end else begin
            state_nxt = wgg_pkg::S_GOAL;
          end
        end
      end
      wgg_pkg::S_GOAL: begin
        // first sight: the goal is the pose itself
        if (!goal_set_r[robot_r]) begin
          goal_we   = 1'b1;
          goal_init = 1'b1;
        end
        mul_a     = 18'($unsigned(thresh_r));
        mul_b     = 23'($unsigned(thresh_r));
        state_nxt = wgg_pkg::S_DIFF;
      end
      wgg_pkg::S_DIFF: begin
        if (!res_took_r) begin
          thr2_nxt = mul_p[31:0];
        end
        dx_nxt    = $signed({1'b0, goal_x[robot_r]}) - $signed({1'b0, px_r});
        dy_nxt    = $signed({1'b0, goal_y[robot_r]}) - $signed({1'b0, py_r});
        state_nxt = wgg_pkg::S_SQX;
      end
      wgg_pkg::S_SQX: begin
        mul_a     = 18'(dx_r);
        mul_b     = 23'(dx_r);
        state_nxt = wgg_pkg::S_SQY;
      end
      wgg_pkg::S_SQY: begin
        sx_nxt    = mul_p[32:0];
        mul_a     = 18'(dy_r);
        mul_b     = 23'(dy_r);
        state_nxt = wgg_pkg::S_SUM;
      end
      wgg_pkg::S_SUM: begin
        s_nxt     = sx_r + mul_p[32:0];
        state_nxt = wgg_pkg::S_CHK;
      end
      wgg_pkg::S_CHK: begin
        if ((s_r < 33'(thr2_r)) && !res_took_r && (qstat.count != '0)) begin
          // within reach, none taken yet for this item and a waypoint is queued: it becomes the new goal
          qctl.pop     = 1'b1;
          goal_we      = 1'b1;
          goal_wx      = qstat.head[31:16];
          goal_wy      = qstat.head[15:0];
          res_took_nxt = 1'b1;
          state_nxt    = wgg_pkg::S_DIFF;
        end else if (s_r < 33'(thr2_r)) begin
          res_arr_nxt = 1'b1;
          state_nxt   = wgg_pkg::S_OUT;
        end else if (s_r == '0) begin
          state_nxt = wgg_pkg::S_OUT;
        end else begin
          v_nxt     = 34'(s_r);
          rt_nxt    = '0;
          b_nxt     = 34'd1 << 32;
          cnt_nxt   = wgg_pkg::SQRT_STEPS_M1;
          state_nxt = wgg_pkg::S_SQRT;
        end
      end
      wgg_pkg::S_SQRT: begin
        // one result bit per cycle
        if (35'(v_r) >= rb_sum) begin
          v_nxt  = v_r - rb_sum[33:0];
          rt_nxt = (rt_r >> 1) + b_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        b_nxt   = b_r >> 2;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = wgg_pkg::S_LIN;
        end
      end
      wgg_pkg::S_LIN: begin
        mul_a     = 18'($unsigned(lin_gain_r));
        mul_b     = 23'($unsigned(rt_r[16:0]));
        state_nxt = wgg_pkg::S_LINC;
      end
      wgg_pkg::S_LINC: begin
        res_lin_nxt = (|mul_p[40:30]) ? 16'hffff : mul_p[29:14];
        // left half-plane pre-rotation by a quarter turn
        if (cdx < 0) begin
          if (cdy >= 0) begin
            x_nxt = 32'(cdy) <<< 12;
            y_nxt = -(32'(cdx) <<< 12);
            z_nxt = 20'(wgg_pkg::ANG_HALF_PI);
          end else begin
            x_nxt = -(32'(cdy) <<< 12);
            y_nxt = 32'(cdx) <<< 12;
            z_nxt = -20'(wgg_pkg::ANG_HALF_PI);
          end
        end else begin
          x_nxt = 32'(cdx) <<< 12;
          y_nxt = 32'(cdy) <<< 12;
          z_nxt = '0;
        end
        cnt_nxt   = '0;
        state_nxt = wgg_pkg::S_CORDIC;
      end
      wgg_pkg::S_CORDIC: begin
        if (y_r > 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_v;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_v;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[3:0] == 4'd15) begin
          state_nxt = wgg_pkg::S_ERR;
        end
      end
      wgg_pkg::S_ERR: begin
        err_nxt   = 22'(z_r) - (22'(hd_r) <<< 4);
        state_nxt = wgg_pkg::S_WRAP;
      end
      wgg_pkg::S_WRAP: begin
        if (err_r > wgg_pkg::ANG_PI) begin
          err_nxt = err_r - wgg_pkg::ANG_TWO_PI;
        end else if (err_r <= -wgg_pkg::ANG_PI) begin
          err_nxt = err_r + wgg_pkg::ANG_TWO_PI;
        end else begin
          state_nxt = wgg_pkg::S_FOLD;
        end
      end
      wgg_pkg::S_FOLD: begin
        if (err_r > wgg_pkg::ANG_HALF_PI) begin
          err_nxt = wgg_pkg::ANG_PI - err_r;
        end else if (err_r < -wgg_pkg::ANG_HALF_PI) begin
          err_nxt = -wgg_pkg::ANG_PI - err_r;
        end
        state_nxt = wgg_pkg::S_ANG;
      end
      wgg_pkg::S_ANG: begin
        mul_a     = 18'($unsigned(ang_gain_r));
        mul_b     = 23'(err_r);
        state_nxt = wgg_pkg::S_ANGC;
      end
      wgg_pkg::S_ANGC: begin
        if (ang_q > 25'sd32767) begin
          res_ang_nxt = 16'sh7fff;
        end else if (ang_q < -25'sd32768) begin
          res_ang_nxt = -16'sh8000;
        end else begin
          res_ang_nxt = ang_q[15:0];
        end
        state_nxt = wgg_pkg::S_OUT;
      end
      wgg_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {5'd0, res_drop_r, res_took_r, res_arr_r,
                           res_ang_r, res_lin_r};
          out_valid_nxt = 1'b1;
          state_nxt     = wgg_pkg::S_IDLE;
        end
      end
      default: state_nxt = wgg_pkg::S_IDLE;
    endcase
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= wgg_pkg::QCNT_W'(wgg_pkg::QUEUE_DEPTH))
    else $error("waypoint queue count beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("item accepted while the sequencer stays idle");

  a_arrived_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> (out_tdata[31:0] == 32'd0))
    else $error("arrived with nonzero drive");

  a_drop_only_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[34]) |-> (out_tdata[33:0] == 34'd0))
    else $error("dropped flag with pose result fields");

endmodule
